[src/isr_pkg.sv]
// Shared constants, types and command/status bundles for the integer square root block.
`timescale 1ns / 1ps

package isr_pkg;

   // Operand and result widths
   localparam int VALUE_WIDTH    = 31;
   localparam int ROOT_WIDTH     = 16;
   localparam int PRODUCT_WIDTH  = 2 * VALUE_WIDTH;
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((ROOT_WIDTH + 7) / 8) * 8;

   typedef logic [VALUE_WIDTH-1:0]   value_type;
   typedef logic [PRODUCT_WIDTH-1:0] product_type;
   typedef logic [ROOT_WIDTH-1:0]    root_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_MID    = 5'b00010,
      S_SQUARE = 5'b00100,
      S_UPDATE = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;     // take a new operand and seed the bounds
      logic mid;      // register the midpoint of the bounds
      logic square;   // register the midpoint squared
      logic update;   // narrow the bounds by the compare
      logic publish;  // load the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic done;     // low bound has met the high bound
   } status_type;

endpackage

[src/isr_ctrl.sv]
// Controller state machine: sequences midpoint, square and compare steps and owns the handshakes.
`timescale 1ns / 1ps

module isr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  isr_pkg::status_type status,
   output isr_pkg::cmd_type    cmd
);

   isr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Result register may be loaded when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == isr_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         isr_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = isr_pkg::S_MID;
            end
         end
         isr_pkg::S_MID: begin
            if (status.done) begin
               state_in = isr_pkg::S_FINISH;
            end else begin
               cmd.mid  = 1'b1;
               state_in = isr_pkg::S_SQUARE;
            end
         end
         isr_pkg::S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = isr_pkg::S_UPDATE;
         end
         isr_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = isr_pkg::S_MID;
         end
         isr_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = isr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = isr_pkg::S_IDLE;
         end
      endcase
   end

   // Output valid: set on publish, drop once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/isr_dp.sv]
// Datapath: operand, search bounds, midpoint, square and result registers.
`timescale 1ns / 1ps

module isr_dp (
   input  logic                clock,
   input  isr_pkg::value_type  value,
   input  isr_pkg::cmd_type    cmd,
   output isr_pkg::status_type status,
   output isr_pkg::root_type   root
);

   isr_pkg::value_type   operand_ff, operand_in;
   isr_pkg::value_type   low_ff, low_in;
   isr_pkg::value_type   high_ff, high_in;
   isr_pkg::value_type   mid_ff, mid_in;
   isr_pkg::product_type square_ff, square_in;
   isr_pkg::root_type    root_ff, root_in;
   logic                 too_big;

   // Midpoint of the current bounds without overflow
   assign mid_in    = low_ff + ((high_ff - low_ff) >> 1);
   assign square_in = isr_pkg::PRODUCT_WIDTH'(mid_ff) * isr_pkg::PRODUCT_WIDTH'(mid_ff);
   assign too_big   = square_ff > isr_pkg::PRODUCT_WIDTH'(operand_ff);

   // Seed or narrow the bounds; zero, one and two finish at once
   always_comb begin
      operand_in = operand_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      if (cmd.load) begin
         operand_in = value;
         if (value == '0) begin
            low_in  = isr_pkg::VALUE_WIDTH'(1);
            high_in = isr_pkg::VALUE_WIDTH'(1);
         end else if (value <= isr_pkg::VALUE_WIDTH'(2)) begin
            low_in  = isr_pkg::VALUE_WIDTH'(2);
            high_in = isr_pkg::VALUE_WIDTH'(2);
         end else begin
            low_in  = isr_pkg::VALUE_WIDTH'(1);
            high_in = value - isr_pkg::VALUE_WIDTH'(1);
         end
      end else if (cmd.update) begin
         if (too_big) begin
            high_in = mid_ff;
         end else begin
            low_in = mid_ff + isr_pkg::VALUE_WIDTH'(1);
         end
      end
   end

   // Root is one below the final low bound
   assign root_in = isr_pkg::ROOT_WIDTH'(low_ff - isr_pkg::VALUE_WIDTH'(1));

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      if (cmd.mid) begin
         mid_ff <= mid_in;
      end
      if (cmd.square) begin
         square_ff <= square_in;
      end
      if (cmd.publish) begin
         root_ff <= root_in;
      end
   end

   assign status.done = (low_ff >= high_ff);
   assign root        = root_ff;

endmodule

[src/integer_square_root.sv]
// Top level of the integer square root block: floor square root by binary search.
//
//   channel  | direction | tdata fields (lowest bit up)        | tuser | tlast
//   req_     | in        | value[30:0], pad[31]                | -     | -
//   rsp_     | out       | root[15:0]                          | -     | -
//
// One item at a time. A transfer in seeds the bounds, then each halving step
// registers the midpoint, squares it on the one multiplier and narrows the
// bounds by the compare; a check of the bounds ends the search, and the result
// register is loaded once the output is free. Values 0 to 2 skip the halving steps.
// A new item is taken while a finished result still waits in the output register.
// Reset empties the output register and returns the controller to idle.
`timescale 1ns / 1ps

module integer_square_root (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [isr_pkg::REQ_DATA_WIDTH-1:0] req_tdata,   // value[30:0], zero pad above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [isr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata    // root[15:0]
);

   isr_pkg::cmd_type    cmd;
   isr_pkg::status_type status;
   isr_pkg::root_type   root;
   isr_pkg::value_type  value;

   // Unpack the operand from the input transfer
   assign value     = req_tdata[isr_pkg::VALUE_WIDTH-1:0];
   assign rsp_tdata = isr_pkg::RSP_DATA_WIDTH'(root);

   isr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   isr_dp u_dp (
      .clock  (clock),
      .value  (value),
      .cmd    (cmd),
      .status (status),
      .root   (root)
   );

endmodule

[src/isr_checker.sv]
// Port-level checker for the integer square root block, bound to the top level.
`timescale 1ns / 1ps

module isr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [isr_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [isr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // Come out of reset idle and empty
   assert property (@(posedge clock) reset |=> (req_tready && !rsp_tvalid))
      else $error("isr: not idle and empty after reset");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("isr: stalled result changed or dropped");

   // Take one item at a time: busy right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("isr: input taken while a search is running");

   // No result can appear in the cycle right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (!rsp_tvalid || rsp_tready)) |=> !rsp_tvalid)
      else $error("isr: result appeared too early");

endmodule

bind integer_square_root isr_checker u_isr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
